@@ design/iss_pkg.sv @@
// Shared types and codes for the indexed sequence store.
package iss_pkg;

    localparam int KIND_W = 4;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int FPOS_W = 4;
    localparam int CNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT_AT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE_AT  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_NTH_FRONT  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NTH_BACK   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } iss_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] read_value;
        logic [FPOS_W-1:0]       found_position;
        logic [CNT_W-1:0]        count;
    } iss_out_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic shift_rd;
        logic shift_wr;
        logic commit;
        logic nth_rd;
        logic nth_cap;
        logic scan_rd;
        logic scan_cmp;
        logic load_out;
    } iss_cmd_t;

    typedef struct packed {
        logic finish;
        logic is_ins;
        logic is_del;
        logic is_nth;
        logic is_srch;
        logic shift_more;
        logic scan_stop;
    } iss_sts_t;

endpackage

@@ design/iss_dpath.sv @@
// Datapath: entry memory, operation checks, index registers and result register.
module iss_dpath #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  iss_pkg::iss_in_t  s_data,
    output iss_pkg::iss_out_t m_data,
    input  iss_pkg::iss_cmd_t cmd,
    output iss_pkg::iss_sts_t sts
);
    import iss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;

    iss_in_t                 in_reg;
    iss_out_t                out_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           at_reg;
    logic [CW-1:0]           fpos_reg;
    logic [STAT_W-1:0]       status_reg;
    logic signed [VAL_W-1:0] rd_reg;

    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     fpos_x;
    logic [XW-1:0]     cnt_out_x;
    logic [CW:0]       idx_p1;
    logic              full;
    logic              empty;
    logic              hit;
    logic              scan_last;
    logic [STAT_W-1:0] chk_status;
    logic              chk_finish;
    logic [CW-1:0]     at_init;
    logic [CW-1:0]     idx_init;
    logic              is_ins;
    logic              is_del;
    logic              is_nth;
    logic              is_srch;
    logic              we;
    logic              re;
    logic [CW-1:0]     waddr;
    logic [CW-1:0]     raddr;
    logic signed [VAL_W-1:0] wdata;

    assign cnt_x     = XW'(count_reg);
    assign pos_x     = XW'(in_reg.position);
    assign fpos_x    = XW'(fpos_reg);
    assign cnt_out_x = XW'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_p1    = {1'b0, idx_reg} + (CW+1)'(1);
    assign hit       = (rdata_reg == in_reg.value);
    assign scan_last = !(idx_p1 < {1'b0, count_reg});

    always_comb begin
        chk_status = ST_OK;
        chk_finish = 1'b0;
        at_init    = '0;
        idx_init   = '0;
        is_ins     = 1'b0;
        is_del     = 1'b0;
        is_nth     = 1'b0;
        is_srch    = 1'b0;
        case (in_reg.kind)
            KIND_PUSH_BACK: begin
                is_ins  = 1'b1;
                at_init = count_reg;
                if (full) begin
                    chk_status = ST_FULL;
                    chk_finish = 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                is_ins = 1'b1;
                if (full) begin
                    chk_status = ST_FULL;
                    chk_finish = 1'b1;
                end
            end
            KIND_INSERT_AT: begin
                is_ins  = 1'b1;
                at_init = pos_x[CW-1:0];
                if (pos_x > cnt_x) begin
                    chk_status = ST_RANGE;
                    chk_finish = 1'b1;
                end else if (full) begin
                    chk_status = ST_FULL;
                    chk_finish = 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                is_del = 1'b1;
                if (empty) begin
                    chk_status = ST_EMPTY;
                    chk_finish = 1'b1;
                end
            end
            KIND_POP_BACK: begin
                is_del  = 1'b1;
                at_init = count_reg - CW'(1);
                if (empty) begin
                    chk_status = ST_EMPTY;
                    chk_finish = 1'b1;
                end
            end
            KIND_DELETE_AT: begin
                is_del  = 1'b1;
                at_init = pos_x[CW-1:0];
                if (empty) begin
                    chk_status = ST_EMPTY;
                    chk_finish = 1'b1;
                end else if (pos_x >= cnt_x) begin
                    chk_status = ST_RANGE;
                    chk_finish = 1'b1;
                end
            end
            KIND_NTH_FRONT, KIND_NTH_BACK: begin
                is_nth = 1'b1;
                if (in_reg.kind == KIND_NTH_FRONT) begin
                    idx_init = pos_x[CW-1:0] - CW'(1);
                end else begin
                    idx_init = count_reg - pos_x[CW-1:0];
                end
                if (empty) begin
                    chk_status = ST_EMPTY;
                    chk_finish = 1'b1;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    chk_status = ST_RANGE;
                    chk_finish = 1'b1;
                end
            end
            KIND_SEARCH: begin
                is_srch    = 1'b1;
                chk_status = ST_NOTFOUND;
                chk_finish = empty;
            end
            default: begin
                chk_finish = 1'b1;
            end
        endcase
        if (is_ins) begin
            idx_init = count_reg;
        end
        if (is_del) begin
            idx_init = at_init;
        end
    end

    always_comb begin
        sts.finish     = chk_finish;
        sts.is_ins     = is_ins;
        sts.is_del     = is_del;
        sts.is_nth     = is_nth;
        sts.is_srch    = is_srch;
        sts.shift_more = is_ins ? (idx_reg > at_reg) : (idx_p1 < {1'b0, count_reg});
        sts.scan_stop  = hit || scan_last;
    end

    always_comb begin
        re    = cmd.shift_rd || cmd.nth_rd || cmd.scan_rd;
        raddr = idx_reg;
        if (cmd.shift_rd) begin
            raddr = is_ins ? (idx_reg - CW'(1)) : idx_p1[CW-1:0];
        end
        we    = cmd.shift_wr || (cmd.commit && is_ins);
        waddr = cmd.shift_wr ? idx_reg : at_reg;
        wdata = cmd.shift_wr ? rdata_reg : in_reg.value;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= is_ins ? (count_reg + CW'(1)) : (count_reg - CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.check) begin
            status_reg <= chk_status;
            rd_reg     <= '0;
            fpos_reg   <= '0;
            idx_reg    <= idx_init;
            at_reg     <= at_init;
        end
        if (cmd.shift_wr) begin
            idx_reg <= is_ins ? (idx_reg - CW'(1)) : idx_p1[CW-1:0];
        end
        if (cmd.scan_cmp) begin
            if (hit) begin
                status_reg <= ST_OK;
                fpos_reg   <= idx_reg;
            end else if (!scan_last) begin
                idx_reg <= idx_p1[CW-1:0];
            end
        end
        if (cmd.nth_cap) begin
            rd_reg <= rdata_reg;
        end
        if (cmd.load_out) begin
            out_reg.status         <= status_reg;
            out_reg.read_value     <= rd_reg;
            out_reg.found_position <= fpos_x[FPOS_W-1:0];
            out_reg.count          <= cnt_out_x[CNT_W-1:0];
        end
    end

    assign m_data = out_reg;

endmodule

@@ design/iss_ctrl.sv @@
// Controller: sequences each operation and holds the result beat valid.
module iss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  iss_pkg::iss_sts_t sts,
    output iss_pkg::iss_cmd_t cmd
);
    import iss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_CHECK    = 10'b0000000010,
        S_SHIFT_RD = 10'b0000000100,
        S_SHIFT_WR = 10'b0000001000,
        S_COMMIT   = 10'b0000010000,
        S_NTH_RD   = 10'b0000100000,
        S_NTH_CAP  = 10'b0001000000,
        S_SCAN_RD  = 10'b0010000000,
        S_SCAN_CMP = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.finish) begin
                    state_next = S_DONE;
                end else if (sts.is_ins || sts.is_del) begin
                    state_next = S_SHIFT_RD;
                end else if (sts.is_nth) begin
                    state_next = S_NTH_RD;
                end else if (sts.is_srch) begin
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                if (sts.shift_more) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_NTH_RD: begin
                cmd.nth_rd = 1'b1;
                state_next = S_NTH_CAP;
            end
            S_NTH_CAP: begin
                cmd.nth_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                cmd.scan_cmp = 1'b1;
                state_next   = sts.scan_stop ? S_DONE : S_SCAN_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ design/indexed_sequence_store.sv @@
// Top level of the indexed sequence store: ordered list with positional access.
//
//  Channel  Direction  Handshake           Beat payload
//  s_       in         s_valid / s_ready   iss_in_t  (kind, position, value)
//  m_       out        m_valid / m_ready   iss_out_t (status, read_value, found_position, count)
//
// One item at a time, in steps: accept, check, then for an insert or delete a read and a write
// per entry moved and a commit, for an nth read a read and a capture, for a search a read and a
// compare per entry scanned, and last the result load. The entry memory has a registered read.
// Reset clears the entry count only; entries are not cleared and no clearing pass runs.
// One finished result is held in the output register; the next item is accepted while it waits.
module indexed_sequence_store #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iss_pkg::iss_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output iss_pkg::iss_out_t m_data
);
    import iss_pkg::*;

    iss_cmd_t cmd;
    iss_sts_t sts;

    iss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iss_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while an operation is in progress");

    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> $past(cmd.shift_rd))
        else $error("shift write without preceding shift read");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result loaded but beat not presented");

endmodule

@@ verif/indexed_sequence_store_test.sv @@
// Self-checking testbench for indexed_sequence_store: directed, random and stalled traffic.
module indexed_sequence_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iss_pkg::*;

    localparam int DEPTH = 16;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_SEARCH + 4'd1;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    iss_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    iss_out_t m_data;

    indexed_sequence_store #(.DEPTH(DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int unsigned             list_len;
    iss_out_t                pending_results [$];

    bit send_idle_en;
    bit recv_idle_en;
    int hold_off_cycles;

    int mismatches;
    int ops_sent;
    int results_checked;
    int max_len_seen;
    int status_hits [8];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("indexed_sequence_store: mismatch");
        $finish;
    end

    function automatic void open_entry(input int unsigned at, input logic signed [VAL_W-1:0] v);
        for (int i = list_len; i > at; i--) begin
            list_vals[i] = list_vals[i-1];
        end
        list_vals[at] = v;
        list_len++;
    endfunction

    function automatic void close_entry(input int unsigned at);
        for (int i = at; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i+1];
        end
        list_len--;
    endfunction

    function automatic iss_out_t apply_list_op(input iss_in_t op);
        iss_out_t    r;
        bit          is_full;
        int unsigned pos;
        r = '0;
        is_full = (list_len >= DEPTH);
        pos = 32'(op.position);
        case (op.kind)
            KIND_PUSH_BACK: begin
                if (is_full) r.status = ST_FULL;
                else open_entry(list_len, op.value);
            end
            KIND_PUSH_FRONT: begin
                if (is_full) r.status = ST_FULL;
                else open_entry(0, op.value);
            end
            KIND_INSERT_AT: begin
                if (pos > list_len) r.status = ST_RANGE;
                else if (is_full) r.status = ST_FULL;
                else open_entry(pos, op.value);
            end
            KIND_POP_FRONT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else close_entry(0);
            end
            KIND_POP_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else close_entry(list_len - 1);
            end
            KIND_DELETE_AT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (pos >= list_len) r.status = ST_RANGE;
                else close_entry(pos);
            end
            KIND_NTH_FRONT, KIND_NTH_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (pos == 0 || pos > list_len) r.status = ST_RANGE;
                else if (op.kind == KIND_NTH_FRONT) r.read_value = list_vals[pos-1];
                else r.read_value = list_vals[list_len-pos];
            end
            KIND_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int i = int'(list_len) - 1; i >= 0; i--) begin
                    if (list_vals[i] == op.value) begin
                        r.status = ST_OK;
                        r.found_position = FPOS_W'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    task automatic send_op(input iss_in_t op);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 12) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.push_back(apply_list_op(op));
        ops_sent++;
        if (list_len > max_len_seen) max_len_seen = list_len;
    endtask

    task automatic send_fields(input logic [KIND_W-1:0] kind, input int unsigned pos,
                               input logic signed [VAL_W-1:0] v);
        iss_in_t op;
        op.kind     = kind;
        op.position = pos[POS_W-1:0];
        op.value    = v;
        send_op(op);
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = recv_idle_en ? $urandom_range(0, 12) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        iss_out_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no operation outstanding: %p", m_data);
                mismatches++;
            end else begin
                exp = pending_results.pop_front();
                results_checked++;
                status_hits[exp.status]++;
                if (m_data.status !== exp.status) begin
                    $error("status: expected %0d actual %0d", exp.status, m_data.status);
                    mismatches++;
                end
                if (m_data.read_value !== exp.read_value) begin
                    $error("read_value: expected %0d actual %0d",
                           exp.read_value, m_data.read_value);
                    mismatches++;
                end
                if (m_data.found_position !== exp.found_position) begin
                    $error("found_position: expected %0d actual %0d",
                           exp.found_position, m_data.found_position);
                    mismatches++;
                end
                if (m_data.count !== exp.count) begin
                    $error("count: expected %0d actual %0d", exp.count, m_data.count);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [KIND_W-1:0] pick_kind(input int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        if (r < 2 + grow_pct) return KIND_W'($urandom_range(KIND_PUSH_BACK, KIND_INSERT_AT));
        if ($urandom_range(0, 1)) return KIND_W'($urandom_range(KIND_POP_FRONT, KIND_DELETE_AT));
        return KIND_W'($urandom_range(KIND_NTH_FRONT, KIND_SEARCH));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (list_len > 0 && r < 4) return list_vals[$urandom_range(0, list_len - 1)];
        if (r < 6) return $signed(VAL_W'($urandom_range(0, 6))) - 3;
        return $signed($urandom());
    endfunction

    function automatic int unsigned pick_position();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, list_len + 1);
    endfunction

    task automatic send_random(input int n, input int grow_pct);
        for (int i = 0; i < n; i++) begin
            send_fields(pick_kind(grow_pct), pick_position(), pick_value());
        end
    endtask

    task automatic test_empty_list();
        send_fields(KIND_POP_FRONT, 0, 0);
        send_fields(KIND_POP_BACK, 0, 0);
        send_fields(KIND_DELETE_AT, 0, 0);
        send_fields(KIND_NTH_FRONT, 1, 0);
        send_fields(KIND_SEARCH, 0, 0);
        send_fields(KIND_INSERT_AT, 1, 5);
        send_fields(KIND_SPARE_HI, 31, -1);
    endtask

    task automatic test_fill_to_full();
        send_fields(KIND_PUSH_BACK, 0, 32'sh7fffffff);
        send_fields(KIND_PUSH_FRONT, 0, 32'sh80000000);
        send_fields(KIND_INSERT_AT, 2, -1);
        send_fields(KIND_INSERT_AT, 0, 0);
        for (int i = 4; i < DEPTH; i++) begin
            send_fields(KIND_W'(int'(KIND_PUSH_BACK) + i % 3), i / 2, $signed($urandom()));
        end
        send_fields(KIND_PUSH_BACK, 0, 1);
        send_fields(KIND_INSERT_AT, DEPTH, 2);
        send_fields(KIND_INSERT_AT, DEPTH + 1, 3);
    endtask

    task automatic test_full_reads_and_deletes();
        send_fields(KIND_NTH_FRONT, 0, 0);
        send_fields(KIND_NTH_BACK, DEPTH, 0);
        send_fields(KIND_SEARCH, 0, 32'sh80000000);
        send_fields(KIND_DELETE_AT, DEPTH, 0);
        send_fields(KIND_POP_BACK, 0, 0);
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 300;
        send_random(20, 50);
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 5; round++) begin
            send_random(35, 70);
            send_random(25, 15);
        end
    endtask

    task automatic test_no_idle();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        send_random(25, 60);
        send_random(15, 10);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_off_cycles = 0;
        list_len = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_fill_to_full();
        test_full_reads_and_deletes();
        test_back_pressure();
        test_random_mix();
        test_no_idle();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d operations, checked %0d results, longest list %0d",
                 ops_sent, results_checked, max_len_seen);
        $display("status seen: ok %0d, range %0d, empty %0d, full %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
                 status_hits[ST_FULL], status_hits[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("indexed_sequence_store: match");
        end else begin
            $display("indexed_sequence_store: mismatch");
        end
        $finish;
    end

endmodule
